// File: hdl/toeq_pkg.sv
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared types, constants and helpers for the time-ordered event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package toeq_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 64;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index
  localparam int CW       = $clog2(CAPACITY + 1);                   // fill count

  // Request codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_POP,
    ST_EMIT
  } state_t;

  // One stored event
  typedef struct packed {
    logic        [30:0] ev_time;
    logic        [7:0]  ev_kind;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
  } slot_t;

  // Write port of the slot store
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    slot_t         data;
  } ram_wr_t;

  // Physical slot of logical position off in the ring that starts at base
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Stable min-time event queue: events are kept sorted by time in a ring of
// memory slots; equal times leave in arrival order.
// ----------------------------------------------------------------------------
//
//   channel  ports                                  flow
//   -------  -------------------------------------  ----------------------
//   in       in_valid/in_stall, in_cmd, in_event_*  insert or pop request
//            in_payload_a, in_payload_b
//   out      out_valid/out_stall, out_status,       one result per request
//            out_time, out_kind, out_payload_*,
//            out_now_empty
//
// A pop reads the head slot; an insert moves each stored event with a later
// time up one slot (one slot moved per cycle through the single read and
// write port of the slot memory), then writes the new event into the freed
// slot. Refused requests and an insert into an empty queue finish when
// accepted; a stalled result parks until the output register frees. Reset
// (rst_n low, synchronous) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module time_ordered_event_queue (
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  // request channel
  input  wire  logic               in_valid,
  output logic                     in_stall,
  input  wire  logic               in_cmd,
  input  wire  logic        [30:0] in_event_time,
  input  wire  logic        [7:0]  in_event_kind,
  input  wire  logic signed [31:0] in_payload_a,
  input  wire  logic signed [31:0] in_payload_b,
  // result channel
  output logic                     out_valid,
  input  wire  logic               out_stall,
  output logic              [1:0]  out_status,
  output logic              [30:0] out_time,
  output logic              [7:0]  out_kind,
  output logic signed       [31:0] out_payload_a,
  output logic signed       [31:0] out_payload_b,
  output logic                     out_now_empty
);
  import toeq_pkg::*;

  // Control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r,  head_nxt;
  logic [CW-1:0] fill_r,  fill_nxt;
  logic [AW-1:0] pos_r,   pos_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers
  slot_t         req_r,   req_nxt;
  status_t       res_status_r, res_status_nxt;
  slot_t         res_slot_r,   res_slot_nxt;
  logic          res_empty_r,  res_empty_nxt;
  status_t       out_status_r, out_status_nxt;
  slot_t         out_slot_r,   out_slot_nxt;
  logic          out_empty_r,  out_empty_nxt;

  // Memory interface
  ram_wr_t       wr;
  logic [AW-1:0] rd_addr;
  slot_t         rd_data;

  // Completion of a request this cycle
  logic          fin;
  status_t       fin_status;
  slot_t         fin_slot;
  logic          fin_empty;
  logic          out_free;
  logic          accept;
  slot_t         in_slot;

  toeq_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign in_slot = '{ev_time: in_event_time, ev_kind: in_event_kind,
                     pa: in_payload_a, pb: in_payload_b};
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state and memory control
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    req_nxt        = req_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_empty_nxt  = res_empty_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_empty_nxt  = out_empty_r;
    out_valid_nxt  = out_valid_r && out_stall;
    wr             = '0;
    rd_addr        = head_r;
    fin            = 1'b0;
    fin_status     = STAT_DONE;
    fin_slot       = '0;
    fin_empty      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_slot;
          if (cmd_t'(in_cmd) == CMD_INSERT) begin
            if (fill_r == CW'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = STAT_FULL;
            end else if (fill_r == '0) begin
              // first event goes straight to the head slot
              wr.en    = 1'b1;
              wr.addr  = head_r;
              wr.data  = in_slot;
              fill_nxt = CW'(1);
              fin      = 1'b1;
            end else begin
              // start scanning from the latest event
              pos_nxt   = AW'(fill_r - CW'(1));
              rd_addr   = phys_addr(head_r, AW'(fill_r - CW'(1)));
              state_nxt = ST_INS;
            end
          end else begin
            if (fill_r == '0) begin
              fin        = 1'b1;
              fin_status = STAT_EMPTY;
              fin_empty  = 1'b1;
            end else begin
              rd_addr   = head_r;
              state_nxt = ST_POP;
            end
          end
        end
      end

      ST_INS: begin
        // slot pos+1 gets either the later event moved up or the new event
        wr.en   = 1'b1;
        wr.addr = phys_addr(head_r, pos_r + AW'(1));
        if (rd_data.ev_time > req_r.ev_time) begin
          wr.data = rd_data;
          if (pos_r == '0) begin
            state_nxt = ST_PUT;
          end else begin
            pos_nxt = pos_r - AW'(1);
            rd_addr = phys_addr(head_r, pos_r - AW'(1));
          end
        end else begin
          wr.data   = req_r;
          fill_nxt  = fill_r + CW'(1);
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_PUT: begin
        // new event is the earliest
        wr.en     = 1'b1;
        wr.addr   = head_r;
        wr.data   = req_r;
        fill_nxt  = fill_r + CW'(1);
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_POP: begin
        fin       = 1'b1;
        fin_slot  = rd_data;
        fin_empty = (fill_r == CW'(1));
        fill_nxt  = fill_r - CW'(1);
        head_nxt  = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
        state_nxt = ST_IDLE;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_empty_nxt  = res_empty_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result goes to the output register, or parks until it frees
    if (fin) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_slot_nxt   = fin_slot;
        out_empty_nxt  = fin_empty;
      end else begin
        res_status_nxt = fin_status;
        res_slot_nxt   = fin_slot;
        res_empty_nxt  = fin_empty;
        state_nxt      = ST_EMIT;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_empty_r  <= res_empty_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // Result ports
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_time      = out_slot_r.ev_time;
  assign out_kind      = out_slot_r.ev_kind;
  assign out_payload_a = out_slot_r.pa;
  assign out_payload_b = out_slot_r.pb;
  assign out_now_empty = out_empty_r;

endmodule

`default_nettype wire

// File: hdl/toeq_store.sv
// ----------------------------------------------------------------------------
// toeq_store
// Event slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module toeq_store (
  input  wire logic             clk,
  input  wire toeq_pkg::ram_wr_t wr,
  input  wire logic [toeq_pkg::AW-1:0] rd_addr,
  output toeq_pkg::slot_t       rd_data_r
);
  import toeq_pkg::*;

  slot_t mem [CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time-ordered event queue. Inserts and pops
// are sent over the valid/stall request channel. A shadow list, kept sorted
// by event time with ties in arrival order, predicts every result. Results
// are compared field by field as they leave the block. The run covers
// ordering and tie cases, full and empty refusals, fill/drain sweeps, random
// traffic under changing idle patterns, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int MAX_PRINTS   = 40;

  // One predicted result
  typedef struct packed {
    status_t status;
    slot_t   ev;
    logic    now_empty;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic        [30:0] in_event_time = '0;
  logic        [7:0]  in_event_kind = '0;
  logic signed [31:0] in_payload_a = '0;
  logic signed [31:0] in_payload_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [1:0]  out_status;
  logic        [30:0] out_time;
  logic        [7:0]  out_kind;
  logic signed [31:0] out_payload_a;
  logic signed [31:0] out_payload_b;
  logic               out_now_empty;

  // Shadow of the sorted store and the results still owed by the block
  slot_t   sorted_events[$];
  result_t pending_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int n_errors    = 0;
  int n_checked   = 0;
  int n_inserts   = 0;
  int n_pops      = 0;
  int n_full      = 0;
  int n_empty     = 0;

  time_ordered_event_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_event_time (in_event_time),
    .in_event_kind (in_event_kind),
    .in_payload_a  (in_payload_a),
    .in_payload_b  (in_payload_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_time      (out_time),
    .out_kind      (out_kind),
    .out_payload_a (out_payload_a),
    .out_payload_b (out_payload_b),
    .out_now_empty (out_now_empty)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run-time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("time_ordered_event_queue regression: fail");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS) begin
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h (result %0d)",
               $time, what, got, want, n_checked);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request owed", 64'(out_status), 64'(0));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_status != want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_time != want.ev.ev_time)
          report_mismatch("time", 64'(out_time), 64'(want.ev.ev_time));
        if (out_kind != want.ev.ev_kind)
          report_mismatch("kind", 64'(out_kind), 64'(want.ev.ev_kind));
        if (out_payload_a != want.ev.pa)
          report_mismatch("payload_a", 64'($unsigned(out_payload_a)),
                          64'($unsigned(want.ev.pa)));
        if (out_payload_b != want.ev.pb)
          report_mismatch("payload_b", 64'($unsigned(out_payload_b)),
                          64'($unsigned(want.ev.pb)));
        if (out_now_empty != want.now_empty)
          report_mismatch("now_empty", 64'(out_now_empty), 64'(want.now_empty));
      end
    end
  end

  // Queue behavior for one accepted request
  task automatic apply_request(input cmd_t cmd, input slot_t ev);
    result_t r;
    int      pos;
    r        = '0;
    r.status = STAT_DONE;
    if (cmd == CMD_INSERT) begin
      n_inserts++;
      if (sorted_events.size() >= CAPACITY) begin
        r.status = STAT_FULL;
        n_full++;
      end else begin
        // stable: land after every event with time <= ours
        pos = 0;
        while (pos < sorted_events.size() && sorted_events[pos].ev_time <= ev.ev_time)
          pos++;
        sorted_events.insert(pos, ev);
      end
    end else begin
      n_pops++;
      if (sorted_events.size() == 0) begin
        r.status = STAT_EMPTY;
        n_empty++;
      end else begin
        r.ev = sorted_events.pop_front();
      end
    end
    r.now_empty = (sorted_events.size() == 0);
    pending_results.push_back(r);
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(input cmd_t cmd, input slot_t ev);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_event_time <= ev.ev_time;
    in_event_kind <= ev.ev_kind;
    in_payload_a  <= ev.pa;
    in_payload_b  <= ev.pb;
    do @(posedge clk); while (in_stall);
    apply_request(cmd, ev);
  endtask

  // Time mix: dense ties, small, near top of range, anything
  function automatic logic [30:0] rand_time();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(15));
      1:       return 31'($urandom_range(1000));
      2:       return 31'h7FFF_FFFF - 31'($urandom_range(15));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic slot_t rand_event();
    slot_t ev;
    ev.ev_time = rand_time();
    ev.ev_kind = 8'($urandom);
    ev.pa      = $urandom;
    ev.pb      = $urandom;
    return ev;
  endfunction

  function automatic slot_t make_event(input logic [30:0] t, input logic [7:0] k,
                                       input logic [31:0] a, input logic [31:0] b);
    slot_t ev;
    ev.ev_time = t;
    ev.ev_kind = k;
    ev.pa      = a;
    ev.pb      = b;
    return ev;
  endfunction

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Extremes, front/back placement, equal-time order, empty pops
  task automatic test_directed_order();
    send_request(CMD_POP, rand_event());
    send_request(CMD_INSERT, make_event(31'd100, 8'd1, 32'h0, 32'hFFFF_FFFF));
    send_request(CMD_INSERT, make_event(31'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(CMD_INSERT, make_event(31'h7FFF_FFFF, 8'hFF, 32'h7FFF_FFFF,
                                        32'h8000_0000));
    send_request(CMD_INSERT, make_event(31'd100, 8'd2, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(CMD_INSERT, make_event(31'd100, 8'd3, 32'hAAAA_AAAA, 32'h5555_5555));
    send_request(CMD_INSERT, make_event(31'd100, 8'd4, 32'h1, 32'h2));
    send_request(CMD_INSERT, make_event(31'd99, 8'd5, 32'h3, 32'h4));
    repeat (7) send_request(CMD_POP, rand_event());
    send_request(CMD_POP, rand_event());
    send_request(CMD_INSERT, make_event(31'h7FFF_FFFF, 8'h80, 32'hFFFF_FFFF, 32'h0));
    send_request(CMD_POP, rand_event());
  endtask

  // Fill to capacity with tie-heavy times, refuse, then drain past empty
  task automatic test_fill_and_drain();
    slot_t ev;
    while (sorted_events.size() < CAPACITY) begin
      ev = rand_event();
      if ($urandom_range(1))
        ev.ev_time = 31'($urandom_range(7));
      send_request(CMD_INSERT, ev);
    end
    repeat (2) send_request(CMD_INSERT, rand_event());
    while (sorted_events.size() > 0)
      send_request(CMD_POP, rand_event());
    send_request(CMD_POP, rand_event());
  endtask

  // Random mix; insert bias shifts every burst so the fill level wanders
  task automatic test_random_traffic(input int n_items);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 90;
        endcase
      end
      if ($urandom_range(99) < insert_pct)
        send_request(CMD_INSERT, rand_event());
      else
        send_request(CMD_POP, rand_event());
    end
  endtask

  // Long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    rx_hold_req = 400;
    for (int i = 0; i < 70; i++) begin
      if ($urandom_range(99) < 80)
        send_request(CMD_INSERT, rand_event());
      else
        send_request(CMD_POP, rand_event());
    end
  endtask

  // Test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(31, 71);
    test_directed_order();
    test_fill_and_drain();
    test_random_traffic(180);

    set_idling(71, 31);
    test_random_traffic(180);

    set_idling(0, 0);
    test_backpressure();
    test_random_traffic(100);
    test_fill_and_drain();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts (%0d refused full) and %0d pops (%0d on empty queue).",
             n_inserts, n_full, n_pops, n_empty);
    $display("Checked %0d results over %0d cycles; %0d mismatches.",
             n_checked, cycle_count, n_errors);
    if (n_errors == 0) begin
      $display("time_ordered_event_queue regression: pass");
    end else begin
      $display("time_ordered_event_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
